// ----- rtl/grr_pkg.sv -----
// ----------------------------------------------------------------------------
// grr_pkg: shared types and codes for the goal retry reconciler
// Request modes, register indexes and the structs that run between the
// lanes and the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

  localparam int unsigned NumGoals = 4;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic {
    CFG_EFFECT_TIMEOUT = 1'b0,
    CFG_MAX_ATTEMPTS   = 1'b1
  } cfg_index_t;

  localparam logic [31:0] EffectTimeoutReset = 32'd2000;
  localparam logic [7:0]  MaxAttemptsReset   = 8'd3;

  typedef struct packed {
    logic [31:0] effect_timeout;
    logic [7:0]  attempt_limit;
  } cfg_t;

  // One lane's view of an accepted request.
  typedef struct packed {
    logic        accept;
    logic [1:0]  mode;
    logic        sel;      // set request targets this lane
    logic [7:0]  value;    // normalized target
    logic [31:0] now_ms;
    logic [7:0]  seen;     // observation, zero-extended
  } lane_ctl_t;

  // Lane outcome for the request, state after the request.
  typedef struct packed {
    logic       fire;
    logic       active;
    logic       gave_up;
    logic [7:0] cmd_value;
  } lane_res_t;

endpackage

`default_nettype wire

// ----- rtl/grr_if.sv -----
// ----------------------------------------------------------------------------
// grr_if: request and result channels of the goal retry reconciler
// Valid/ready channels; a transfer happens when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface grr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [1:0]  goal_channel;
  logic [7:0]  goal_value;
  logic [31:0] now_ms;
  logic [7:0]  cur_temp;
  logic [7:0]  cur_pump1;
  logic        cur_pump2;
  logic        cur_light;

  modport source (
    output valid, mode, goal_channel, goal_value, now_ms,
           cur_temp, cur_pump1, cur_pump2, cur_light,
    input  ready
  );
  modport sink (
    input  valid, mode, goal_channel, goal_value, now_ms,
           cur_temp, cur_pump1, cur_pump2, cur_light,
    output ready
  );
endinterface

interface grr_out_if;
  logic       valid;
  logic       ready;
  logic       issue_temp;
  logic [7:0] temp_command_value;
  logic       toggle_pump1;
  logic       toggle_pump2;
  logic       toggle_light;
  logic [3:0] gave_up_flags;
  logic [3:0] active_flags;

  modport source (
    output valid, issue_temp, temp_command_value, toggle_pump1,
           toggle_pump2, toggle_light, gave_up_flags, active_flags,
    input  ready
  );
  modport sink (
    input  valid, issue_temp, temp_command_value, toggle_pump1,
           toggle_pump2, toggle_light, gave_up_flags, active_flags,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/goal_retry_reconciler.sv -----
// ----------------------------------------------------------------------------
// goal_retry_reconciler: retries commands toward four device goals
// Tracks temperature, pump1, pump2 and light goals and decides per tick
// which commands to (re)issue and which goals to give up on.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  - requests: tick (time + four observations), set goal, or clear
//            the gave-up flags. Mode three is accepted and ignored.
//   out_ch - one result per request: command strobes, the temperature value
//            for its command, and the gave-up and active flags after the
//            request.
//   cfg_*  - register writes (effect timeout, max attempts); write only while
//            no request is in flight.
// Timing: four goal lanes evaluate a request in parallel in the cycle it is
//   accepted and update their records at that edge; the merge stage registers
//   the result, so it is visible in the cycle after acceptance. One request per
//   cycle is sustained while the receiver takes results; the per-lane 32-bit
//   elapsed-time subtract and compare set the critical path.
// Stall: a single output register; in_ch.ready is high while it is empty or
//   being drained, so a stalled receiver holds off new requests after one.
// Reset: all goals inactive, gave-up flags clear, output empty, timeout 2000
//   and max attempts 3.
// ----------------------------------------------------------------------------
`default_nettype none

module goal_retry_reconciler (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [31:0] cfg_data,
  grr_in_if.sink      in_ch,
  grr_out_if.source   out_ch
);

  grr_pkg::cfg_t      cfg;
  grr_pkg::lane_ctl_t ctl   [grr_pkg::NumGoals];
  grr_pkg::lane_res_t lanes [grr_pkg::NumGoals];
  logic               can_take;
  logic               accept;
  logic [7:0]         seen  [grr_pkg::NumGoals];
  logic [7:0]         value_norm;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.effect_timeout <= grr_pkg::EffectTimeoutReset;
      cfg.attempt_limit  <= grr_pkg::MaxAttemptsReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        grr_pkg::CFG_EFFECT_TIMEOUT: cfg.effect_timeout <= cfg_data;
        grr_pkg::CFG_MAX_ATTEMPTS:   cfg.attempt_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = can_take;
  assign accept      = in_ch.valid && can_take;

  // Binary goals (pump2, light) take any nonzero value as on.
  assign value_norm = in_ch.goal_channel[1] ? {7'd0, (in_ch.goal_value != 8'd0)}
                                            : in_ch.goal_value;

  assign seen[0] = in_ch.cur_temp;
  assign seen[1] = in_ch.cur_pump1;
  assign seen[2] = {7'd0, in_ch.cur_pump2};
  assign seen[3] = {7'd0, in_ch.cur_light};

  for (genvar g = 0; g < grr_pkg::NumGoals; g++) begin : g_lane
    always_comb begin
      ctl[g].accept = accept;
      ctl[g].mode   = in_ch.mode;
      ctl[g].sel    = (in_ch.goal_channel == 2'(g));
      ctl[g].value  = value_norm;
      ctl[g].now_ms = in_ch.now_ms;
      ctl[g].seen   = seen[g];
    end

    grr_lane u_lane (
      .clk (clk),
      .rst (rst),
      .cfg (cfg),
      .ctl (ctl[g]),
      .res (lanes[g])
    );
  end

  grr_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .lanes    (lanes),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  // A goal that gave up is never also pending.
  a_gave_up_not_active: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ((out_ch.gave_up_flags & out_ch.active_flags) == 4'd0))
    else $error("goal both gave up and active");

  // Command value is only carried with a temperature command.
  a_temp_value_gated: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.issue_temp) |-> (out_ch.temp_command_value == 8'd0))
    else $error("temperature value without command");

  // A goal that issued a command stays pending.
  a_fire_keeps_active: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (((~out_ch.active_flags) & {out_ch.toggle_light,
      out_ch.toggle_pump2, out_ch.toggle_pump1, out_ch.issue_temp}) == 4'd0))
    else $error("command issued for inactive goal");

  // Accepted request always yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid)
    else $error("accepted request produced no result");

endmodule

`default_nettype wire

// ----- rtl/grr_lane.sv -----
// ----------------------------------------------------------------------------
// grr_lane: state and retry logic for one goal
// Holds the goal record and its sticky gave-up bit; updates on each request.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_lane (
  input  wire                 clk,
  input  wire                 rst,
  input  grr_pkg::cfg_t       cfg,
  input  grr_pkg::lane_ctl_t  ctl,
  output grr_pkg::lane_res_t  res
);

  logic        active,   active_next;
  logic        waiting,  waiting_next;
  logic        gave_up,  gave_up_next;
  logic [7:0]  target,   target_next;
  logic [7:0]  attempts, attempts_next;
  logic [31:0] issue_time, issue_time_next;
  logic [7:0]  seen_at,  seen_at_next;
  logic        fire;
  logic [31:0] elapsed;
  logic        wait_over;

  assign elapsed   = ctl.now_ms - issue_time;
  assign wait_over = !waiting || (ctl.seen != seen_at) || (elapsed > cfg.effect_timeout);

  always_comb begin
    active_next     = active;
    waiting_next    = waiting;
    gave_up_next    = gave_up;
    target_next     = target;
    attempts_next   = attempts;
    issue_time_next = issue_time;
    seen_at_next    = seen_at;
    fire            = 1'b0;
    unique case (ctl.mode)
      grr_pkg::MODE_SET: begin
        if (ctl.sel) begin
          active_next     = 1'b1;
          target_next     = ctl.value;
          attempts_next   = '0;
          waiting_next    = 1'b0;
          issue_time_next = '0;
          seen_at_next    = '0;
          gave_up_next    = 1'b0;
        end
      end
      grr_pkg::MODE_CLEAR: begin
        gave_up_next = 1'b0;
      end
      grr_pkg::MODE_TICK: begin
        if (active) begin
          if (ctl.seen == target) begin
            active_next   = 1'b0;
            attempts_next = '0;
            waiting_next  = 1'b0;
          end else if (wait_over) begin
            if (attempts < cfg.attempt_limit) begin
              attempts_next   = attempts + 8'd1;
              waiting_next    = 1'b1;
              issue_time_next = ctl.now_ms;
              seen_at_next    = ctl.seen;
              fire            = 1'b1;
            end else begin
              active_next  = 1'b0;
              waiting_next = 1'b0;
              gave_up_next = 1'b1;
            end
          end
        end
      end
      default: ;  // unused mode: no change
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      waiting    <= 1'b0;
      gave_up    <= 1'b0;
      target     <= '0;
      attempts   <= '0;
      issue_time <= '0;
      seen_at    <= '0;
    end else if (ctl.accept) begin
      active     <= active_next;
      waiting    <= waiting_next;
      gave_up    <= gave_up_next;
      target     <= target_next;
      attempts   <= attempts_next;
      issue_time <= issue_time_next;
      seen_at    <= seen_at_next;
    end
  end

  assign res.fire      = fire;
  assign res.active    = active_next;
  assign res.gave_up   = gave_up_next;
  assign res.cmd_value = fire ? target : 8'd0;

endmodule

`default_nettype wire

// ----- rtl/grr_merge.sv -----
// ----------------------------------------------------------------------------
// grr_merge: collects lane outcomes into the result register
// One-entry output register; takes a new result whenever it is empty or
// being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_merge (
  input  wire                clk,
  input  wire                rst,
  input  wire                accept,
  input  grr_pkg::lane_res_t lanes [grr_pkg::NumGoals],
  output logic               can_take,
  grr_out_if.source          out_ch
);

  logic       valid;
  logic       fire_temp;
  logic [7:0] temp_value;
  logic [2:0] toggles;
  logic [3:0] gave_up_flags;
  logic [3:0] active_flags;

  assign can_take = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fire_temp  <= lanes[0].fire;
      temp_value <= lanes[0].cmd_value;
      toggles    <= {lanes[3].fire, lanes[2].fire, lanes[1].fire};
      for (int i = 0; i < grr_pkg::NumGoals; i++) begin
        gave_up_flags[i] <= lanes[i].gave_up;
        active_flags[i]  <= lanes[i].active;
      end
    end
  end

  assign out_ch.valid              = valid;
  assign out_ch.issue_temp         = fire_temp;
  assign out_ch.temp_command_value = temp_value;
  assign out_ch.toggle_pump1       = toggles[0];
  assign out_ch.toggle_pump2       = toggles[1];
  assign out_ch.toggle_light       = toggles[2];
  assign out_ch.gave_up_flags      = gave_up_flags;
  assign out_ch.active_flags       = active_flags;

endmodule

`default_nettype wire

// ----- bench/tb_goal_retry_reconciler.sv -----
// ----------------------------------------------------------------------------
// tb_goal_retry_reconciler: self-checking bench for the goal retry reconciler
// Drives set, clear, tick and unused-mode requests, predicts every result
// from a local model of the four goal records and compares field by field.
// ----------------------------------------------------------------------------

module tb_goal_retry_reconciler;

  // Watchdog limit.
  localparam int unsigned LIMIT_CYCLES    = 200000;
  // Result register latency plus margin, waited once at the end.
  localparam int          TAIL_CYCLES     = 4;
  localparam int          ITEMS_PER_PHASE = 150;

  // Goal slots, same order as the flag bits.
  localparam int GOAL_TEMP  = 0;
  localparam int GOAL_PUMP1 = 1;
  localparam int GOAL_PUMP2 = 2;
  localparam int GOAL_LIGHT = 3;

  // Mode encoding the block must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  goal_channel;
    logic [7:0]  goal_value;
    logic [31:0] now_ms;
    logic [7:0]  cur_temp;
    logic [7:0]  cur_pump1;
    logic        cur_pump2;
    logic        cur_light;
  } request_t;

  typedef struct packed {
    logic       issue_temp;
    logic [7:0] temp_command_value;
    logic       toggle_pump1;
    logic       toggle_pump2;
    logic       toggle_light;
    logic [3:0] gave_up_flags;
    logic [3:0] active_flags;
  } outcome_t;

  // Receiver behavior: always ready, short random stalls, or long stall runs.
  typedef enum int {RX_FREE, RX_CHOPPY, RX_CLOGGED} rx_style_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  grr_pkg::cfg_index_t cfg_index;
  logic [31:0]         cfg_data;

  grr_in_if  in_ch ();
  grr_out_if out_ch ();

  goal_retry_reconciler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Local copy of the goal records and registers.
  logic        goal_on    [grr_pkg::NumGoals];
  logic [7:0]  goal_tgt   [grr_pkg::NumGoals];
  logic [7:0]  goal_tries [grr_pkg::NumGoals];
  logic        goal_wait  [grr_pkg::NumGoals];
  logic [31:0] goal_t0    [grr_pkg::NumGoals];
  logic [7:0]  goal_seen0 [grr_pkg::NumGoals];
  logic [3:0]  gave_up_bits;
  logic [31:0] cfg_timeout;
  logic [7:0]  max_tries;

  outcome_t due_outcomes[$];

  // Stimulus state: plant clock in ms and the last observation per goal.
  logic [31:0] ms_now;
  logic [7:0]  last_obs [grr_pkg::NumGoals];

  int        burst_left;
  int        gap_max;
  rx_style_t rx_style;
  int        rx_hold;

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned reg_writes;
  int unsigned tick_count, set_count, clear_count, ignored_count;
  int unsigned strobe_count, give_up_count;

  // Clock: period 4.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("goal_retry_reconciler regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction: applies one accepted request to the goal records.
  // Goals are walked in channel order; a goal that matches retires, a waiting
  // goal holds until its observation moves or the timeout passes (mod 2^32),
  // then it either reissues or gives up for good.
  // --------------------------------------------------------------------------
  function automatic outcome_t reconcile(request_t r);
    outcome_t    o;
    logic [7:0]  seen [grr_pkg::NumGoals];
    logic [31:0] elapsed;
    logic [3:0]  fired;
    logic [1:0]  ch;
    logic        retry;
    o = '0;
    fired = '0;
    seen[GOAL_TEMP]  = r.cur_temp;
    seen[GOAL_PUMP1] = r.cur_pump1;
    seen[GOAL_PUMP2] = {7'd0, r.cur_pump2};
    seen[GOAL_LIGHT] = {7'd0, r.cur_light};
    case (r.mode)
      grr_pkg::MODE_SET: begin
        ch = r.goal_channel;
        goal_on[ch]    = 1'b1;
        // pump2 and light are on/off goals: any nonzero target means on
        goal_tgt[ch]   = (ch >= 2'(GOAL_PUMP2)) ? {7'd0, |r.goal_value} : r.goal_value;
        goal_tries[ch] = '0;
        goal_wait[ch]  = 1'b0;
        goal_t0[ch]    = '0;
        goal_seen0[ch] = '0;
        gave_up_bits[ch] = 1'b0;
        set_count++;
      end
      grr_pkg::MODE_CLEAR: begin
        gave_up_bits = '0;
        clear_count++;
      end
      grr_pkg::MODE_TICK: begin
        tick_count++;
        for (int k = 0; k < grr_pkg::NumGoals; k++) begin
          if (goal_on[k]) begin
            if (seen[k] == goal_tgt[k]) begin
              goal_on[k]    = 1'b0;
              goal_tries[k] = '0;
              goal_wait[k]  = 1'b0;
            end else begin
              retry = 1'b1;
              if (goal_wait[k]) begin
                elapsed = r.now_ms - goal_t0[k];
                if (seen[k] != goal_seen0[k] || elapsed > cfg_timeout)
                  goal_wait[k] = 1'b0;
                else
                  retry = 1'b0;
              end
              if (retry) begin
                if (goal_tries[k] < max_tries) begin
                  goal_tries[k] = goal_tries[k] + 8'd1;
                  goal_wait[k]  = 1'b1;
                  goal_t0[k]    = r.now_ms;
                  goal_seen0[k] = seen[k];
                  fired[k]      = 1'b1;
                  strobe_count++;
                end else begin
                  goal_on[k]      = 1'b0;
                  gave_up_bits[k] = 1'b1;
                  give_up_count++;
                end
              end
            end
          end
        end
      end
      default: ignored_count++;
    endcase
    o.issue_temp         = fired[GOAL_TEMP];
    o.temp_command_value = fired[GOAL_TEMP] ? goal_tgt[GOAL_TEMP] : 8'd0;
    o.toggle_pump1       = fired[GOAL_PUMP1];
    o.toggle_pump2       = fired[GOAL_PUMP2];
    o.toggle_light       = fired[GOAL_LIGHT];
    o.gave_up_flags      = gave_up_bits;
    for (int k = 0; k < grr_pkg::NumGoals; k++)
      o.active_flags[k] = goal_on[k];
    return o;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking and prediction share one edge process: the result is checked
  // against the oldest prediction first, then any request accepted at this
  // edge is predicted. Register writes update the local copy at the same edge
  // the block takes them.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    request_t req;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_outcomes.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = due_outcomes.pop_front();
          compare_field("issue_temp", 32'(want.issue_temp), 32'(out_ch.issue_temp));
          compare_field("temp_command_value", 32'(want.temp_command_value),
                        32'(out_ch.temp_command_value));
          compare_field("toggle_pump1", 32'(want.toggle_pump1), 32'(out_ch.toggle_pump1));
          compare_field("toggle_pump2", 32'(want.toggle_pump2), 32'(out_ch.toggle_pump2));
          compare_field("toggle_light", 32'(want.toggle_light), 32'(out_ch.toggle_light));
          compare_field("gave_up_flags", 32'(want.gave_up_flags),
                        32'(out_ch.gave_up_flags));
          compare_field("active_flags", 32'(want.active_flags), 32'(out_ch.active_flags));
        end
      end
      if (cfg_we) begin
        reg_writes++;
        case (cfg_index)
          grr_pkg::CFG_EFFECT_TIMEOUT: cfg_timeout = cfg_data;
          grr_pkg::CFG_MAX_ATTEMPTS:   max_tries   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        req.mode         = in_ch.mode;
        req.goal_channel = in_ch.goal_channel;
        req.goal_value   = in_ch.goal_value;
        req.now_ms       = in_ch.now_ms;
        req.cur_temp     = in_ch.cur_temp;
        req.cur_pump1    = in_ch.cur_pump1;
        req.cur_pump2    = in_ch.cur_pump2;
        req.cur_light    = in_ch.cur_light;
        due_outcomes.push_back(reconcile(req));
      end
    end
  end

  // Receiver: ready changes on the falling edge following rx_style.
  always @(negedge clk) begin
    case (rx_style)
      RX_FREE: out_ch.ready <= 1'b1;
      RX_CHOPPY: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold      <= rx_hold - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
          if ($urandom_range(0, 2) == 0)
            rx_hold <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sender. Called and returning on a falling edge. Requests go out in bursts
  // of random length; between bursts valid drops for a random gap (skipped
  // when the gap comes out as zero, so valid never drops and rises in one step).
  // --------------------------------------------------------------------------
  task automatic send_request(request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= r.mode;
    in_ch.goal_channel <= r.goal_channel;
    in_ch.goal_value   <= r.goal_value;
    in_ch.now_ms       <= r.now_ms;
    in_ch.cur_temp     <= r.cur_temp;
    in_ch.cur_pump1    <= r.cur_pump1;
    in_ch.cur_pump2    <= r.cur_pump2;
    in_ch.cur_light    <= r.cur_light;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Hold off new requests until every predicted result has come back.
  // Always crosses at least one edge so valid is not re-raised in this step.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (due_outcomes.size() != 0);
  endtask

  // Registers are only written with the block idle.
  task automatic write_register(grr_pkg::cfg_index_t idx, logic [31:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic request_t pack_request(logic [1:0] mode, logic [1:0] ch, logic [7:0] val,
                                            logic [31:0] now, logic [7:0] temp,
                                            logic [7:0] pump1, logic pump2, logic light);
    request_t r;
    r.mode         = mode;
    r.goal_channel = ch;
    r.goal_value   = val;
    r.now_ms       = now;
    r.cur_temp     = temp;
    r.cur_pump1    = pump1;
    r.cur_pump2    = pump2;
    r.cur_light    = light;
    return r;
  endfunction

  task automatic set_goal(int ch, logic [7:0] val);
    send_request(pack_request(grr_pkg::MODE_SET, ch[1:0], val, $urandom, 8'($urandom),
                              8'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  task automatic tick(logic [31:0] now, logic [7:0] temp, logic [7:0] pump1,
                      logic pump2, logic light);
    send_request(pack_request(grr_pkg::MODE_TICK, 2'($urandom), 8'($urandom), now, temp,
                              pump1, pump2, light));
  endtask

  // Random request. Mostly ticks whose observations either hold (so goals
  // sit waiting), hit the target (retire) or move at random (reissue), with
  // time advancing by zero, exactly the timeout, one past it, small steps or
  // a random jump that may wrap. Sets, clears and unused-mode requests mixed in.
  function automatic request_t random_request();
    request_t   r;
    logic [7:0] obs;
    int         pick;
    r.goal_channel = 2'($urandom);
    r.goal_value   = 8'($urandom);
    r.now_ms       = $urandom;
    r.cur_temp     = 8'($urandom);
    r.cur_pump1    = 8'($urandom);
    r.cur_pump2    = 1'($urandom);
    r.cur_light    = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      r.mode = grr_pkg::MODE_TICK;
      case ($urandom_range(0, 5))
        0: ;
        1: ms_now += cfg_timeout;
        2: ms_now += cfg_timeout + 32'd1;
        3, 4: ms_now += $urandom_range(0, 64);
        default: ms_now += $urandom;
      endcase
      r.now_ms = ms_now;
      for (int k = 0; k < grr_pkg::NumGoals; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: obs = last_obs[k];
          5, 6: obs = goal_tgt[k];
          default: obs = 8'($urandom);
        endcase
        if (k >= GOAL_PUMP2)
          obs = {7'd0, obs[0]};
        last_obs[k] = obs;
      end
      r.cur_temp  = last_obs[GOAL_TEMP];
      r.cur_pump1 = last_obs[GOAL_PUMP1];
      r.cur_pump2 = last_obs[GOAL_PUMP2][0];
      r.cur_light = last_obs[GOAL_LIGHT][0];
    end else if (pick < 93) begin
      r.mode = grr_pkg::MODE_SET;
      if ($urandom_range(0, 3) == 0)
        r.goal_value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else if (pick < 97) begin
      r.mode = grr_pkg::MODE_CLEAR;
    end else begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Nothing armed: tick at the field maxima, an unused-mode request with
  // junk fields, and a clear.
  task automatic test_idle_requests();
    tick(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
    send_request(pack_request(MODE_UNUSED, 2'd3, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
                              1'b1, 1'b1));
    send_request(pack_request(grr_pkg::MODE_CLEAR, 2'd0, 8'h00, 32'h0, 8'h00, 8'h00,
                              1'b0, 1'b0));
  endtask

  // Reset registers (timeout 2000, three attempts). Arms all four goals
  // (pump2 with a nonzero non-one value, light with off) and walks them
  // through issue, waiting at exactly the timeout, reissue one past it,
  // reissue on a changed observation, give-up, retire, and a set that clears
  // one sticky bit before a clear takes the rest.
  task automatic test_retry_cycle();
    set_goal(GOAL_TEMP, 8'hFF);
    set_goal(GOAL_PUMP1, 8'h00);
    set_goal(GOAL_PUMP2, 8'h80);
    set_goal(GOAL_LIGHT, 8'h00);
    tick(32'd100,  8'h00, 8'hFF, 1'b0, 1'b1);
    tick(32'd2100, 8'h00, 8'hFF, 1'b0, 1'b1);
    tick(32'd2101, 8'h00, 8'hFF, 1'b0, 1'b1);
    tick(32'd2102, 8'h10, 8'hFF, 1'b0, 1'b1);
    tick(32'd4102, 8'h10, 8'hFF, 1'b0, 1'b1);
    tick(32'd4103, 8'h10, 8'hFF, 1'b0, 1'b1);
    tick(32'd6200, 8'h10, 8'h00, 1'b1, 1'b1);
    set_goal(GOAL_TEMP, 8'h00);
    tick(32'd6300, 8'h00, 8'h00, 1'b1, 1'b1);
    send_request(pack_request(grr_pkg::MODE_CLEAR, 2'($urandom), 8'($urandom), $urandom,
                              8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)));
  endtask

  // No attempts allowed: an unmet goal gives up on its first tick.
  task automatic test_zero_attempts();
    write_register(grr_pkg::CFG_MAX_ATTEMPTS, 32'd0);
    write_register(grr_pkg::CFG_EFFECT_TIMEOUT, 32'd0);
    set_goal(GOAL_PUMP1, 8'h7F);
    tick(32'd0, 8'h00, 8'h80, 1'b0, 1'b0);
  endtask

  // Elapsed time across the 32-bit wrap: with the largest timeout only a
  // moved observation can end the wait; with a short one the wrapped
  // difference expires it.
  task automatic test_time_wrap();
    write_register(grr_pkg::CFG_EFFECT_TIMEOUT, 32'hFFFF_FFFF);
    write_register(grr_pkg::CFG_MAX_ATTEMPTS, 32'd255);
    set_goal(GOAL_LIGHT, 8'h01);
    tick(32'hFFFF_FFF0, 8'h00, 8'h00, 1'b0, 1'b0);
    tick(32'h0000_0005, 8'h00, 8'h00, 1'b0, 1'b0);
    write_register(grr_pkg::CFG_EFFECT_TIMEOUT, 32'd5);
    tick(32'h0000_0006, 8'h00, 8'h00, 1'b0, 1'b0);
    tick(32'h0000_0007, 8'h00, 8'h00, 1'b0, 1'b1);
  endtask

  // One random phase under one register setting and idling pattern. Halfway
  // through the sender stops until all results are back.
  task automatic test_random_traffic(logic [31:0] timeout, logic [7:0] attempts,
                                     rx_style_t style, int gaps, int count);
    write_register(grr_pkg::CFG_EFFECT_TIMEOUT, timeout);
    write_register(grr_pkg::CFG_MAX_ATTEMPTS, {24'd0, attempts});
    rx_style = style;
    gap_max  = gaps;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2)
        drain_results();
      send_request(random_request());
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = grr_pkg::CFG_EFFECT_TIMEOUT;
    cfg_data  = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = grr_pkg::MODE_TICK;
    in_ch.goal_channel = '0;
    in_ch.goal_value   = '0;
    in_ch.now_ms       = '0;
    in_ch.cur_temp     = '0;
    in_ch.cur_pump1    = '0;
    in_ch.cur_pump2    = 1'b0;
    in_ch.cur_light    = 1'b0;
    out_ch.ready       = 1'b1;

    // Model starts in the reset state.
    for (int k = 0; k < grr_pkg::NumGoals; k++) begin
      goal_on[k]    = 1'b0;
      goal_tgt[k]   = '0;
      goal_tries[k] = '0;
      goal_wait[k]  = 1'b0;
      goal_t0[k]    = '0;
      goal_seen0[k] = '0;
      last_obs[k]   = '0;
    end
    gave_up_bits = '0;
    cfg_timeout  = grr_pkg::EffectTimeoutReset;
    max_tries    = grr_pkg::MaxAttemptsReset;
    ms_now       = '0;
    burst_left   = 0;
    gap_max      = 2;
    rx_style     = RX_CHOPPY;
    rx_hold      = 0;
    mismatches   = 0;
    cycle_count  = 0;
    reg_writes   = 0;
    tick_count   = 0;
    set_count    = 0;
    clear_count  = 0;
    ignored_count = 0;
    strobe_count = 0;
    give_up_count = 0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_idle_requests();
    test_retry_cycle();
    test_zero_attempts();
    test_time_wrap();

    // Register extremes and a few mid settings, cycling through the idling styles.
    test_random_traffic(32'd2000,       8'd3,   RX_FREE,    0,  ITEMS_PER_PHASE);
    test_random_traffic(32'd0,          8'd0,   RX_CHOPPY,  6,  ITEMS_PER_PHASE);
    test_random_traffic(32'hFFFF_FFFF,  8'd255, RX_CLOGGED, 3,  ITEMS_PER_PHASE);
    test_random_traffic(32'd10,         8'd1,   RX_CHOPPY,  12, ITEMS_PER_PHASE);
    test_random_traffic(32'd40,         8'd8,   RX_CLOGGED, 0,  ITEMS_PER_PHASE);
    test_random_traffic($urandom,       8'd2,   RX_FREE,    4,  ITEMS_PER_PHASE);

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("requests: %0d ticks, %0d sets, %0d clears, %0d unused-mode",
             tick_count, set_count, clear_count, ignored_count);
    $display("%0d command strobes, %0d give-ups, %0d register writes, %0d mismatches",
             strobe_count, give_up_count, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("goal_retry_reconciler regression: pass");
    end else begin
      $display("goal_retry_reconciler regression: fail");
    end
    $finish;
  end

endmodule
